// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, off while reset is held
`define GCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, also during reset
`define GCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gcr_pkg.sv -----
package gcr_pkg;

    localparam int unsigned CORDIC_STAGES_DEFAULT = 24;
    localparam int unsigned RADIUS_W = 25;
    localparam int unsigned ANGLE_W  = 32;
    localparam int unsigned RANGE_W  = 27;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 25'd20902259;
    localparam logic signed [33:0]  GAIN_Q30     = 34'sd652032874;
    localparam logic signed [33:0]  ONE_Q30      = 34'sd1073741824;
    localparam logic [30:0]         PI_Q29       = 31'd1686629713;
    localparam logic [RANGE_W-1:0]  RANGE_MAX    = {RANGE_W{1'b1}};

    // Arctangent of 2^-i in binary angle units
    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

endpackage

// ----- rtl/great_circle_range.sv -----
// Channel   Signals                                      Transfer
// input     start, busy, lat_this, lon_this,             start high, busy low
//           lat_other, lon_other
// config    cfg_valid, cfg_ready, cfg_data               cfg_valid and cfg_ready
// result    done, range_feet                             done high, one cycle
//
// A new position pair is taken every cycle; busy is never raised.
// Each result passes from its transfer through two CORDIC pipelines of
// CORDIC_STAGES stages and a 31-stage square root, with registers between them.
// Reset clears the valid line and restores the default radius.
// The receiver cannot stall, so the pipeline advances on every clock.
module great_circle_range #(
    parameter int unsigned CORDIC_STAGES = gcr_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [gcr_pkg::ANGLE_W-1:0]    lat_this,
    input  logic signed [gcr_pkg::ANGLE_W-1:0]    lon_this,
    input  logic signed [gcr_pkg::ANGLE_W-1:0]    lat_other,
    input  logic signed [gcr_pkg::ANGLE_W-1:0]    lon_other,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gcr_pkg::RADIUS_W-1:0]          cfg_data,
    output logic                                  done,
    output logic [gcr_pkg::RANGE_W-1:0]           range_feet
);
    import gcr_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned N      = CORDIC_STAGES;
    localparam int unsigned SQ     = 31;
    localparam int unsigned LAT    = (N + 1) + 3 + (SQ + 1) + N + 3;

    // Radius register
    logic [RADIUS_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Valid line alongside the datapath
    logic [LAT-2:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-3:0], start && !busy};
        end
    end

    // Cosine CORDIC lanes: lat_this, lat_other, dlat, dlon
    logic [31:0]        ang [4];
    logic signed [33:0] cx_reg [4][N+1];
    logic signed [33:0] cy_reg [4][N+1];
    logic signed [33:0] cz_reg [4][N+1];
    logic               cf_reg [4][N+1];

    assign ang[0] = lat_this;
    assign ang[1] = lat_other;
    assign ang[2] = lat_this - lat_other;
    assign ang[3] = lon_this - lon_other;

    genvar k, i;
    generate
        for (k = 0; k < 4; k++)
        begin : g_cos
            logic [31:0] biased;
            logic [31:0] folded;

            // Fold into the right half plane, flip the sign when folded
            assign biased = ang[k] + 32'h4000_0000;
            assign folded = biased[31] ? ang[k] + 32'h8000_0000 : ang[k];

            always_ff @(posedge clk)
            begin
                cx_reg[k][0] <= GAIN_Q30;
                cy_reg[k][0] <= '0;
                cz_reg[k][0] <= {{2{folded[31]}}, folded};
                cf_reg[k][0] <= biased[31];
            end

            for (i = 0; i < N; i++)
            begin : g_it
                logic signed [33:0] dx, dy, at;
                assign dx = cy_reg[k][i] >>> i;
                assign dy = cx_reg[k][i] >>> i;
                assign at = {2'b00, ATAN_BAM[i]};

                // Rotate toward zero residual angle
                always_ff @(posedge clk)
                begin
                    if (!cz_reg[k][i][33])
                    begin
                        cx_reg[k][i+1] <= cx_reg[k][i] - dx;
                        cy_reg[k][i+1] <= cy_reg[k][i] + dy;
                        cz_reg[k][i+1] <= cz_reg[k][i] - at;
                    end
                    else
                    begin
                        cx_reg[k][i+1] <= cx_reg[k][i] + dx;
                        cy_reg[k][i+1] <= cy_reg[k][i] - dy;
                        cz_reg[k][i+1] <= cz_reg[k][i] + at;
                    end
                    cf_reg[k][i+1] <= cf_reg[k][i];
                end
            end
        end
    endgenerate

    // Clamp, flip and form the half-angle terms
    logic signed [33:0] cos_c [4];
    logic signed [33:0] hv_full [2];
    logic signed [31:0] cos1_reg, cos2_reg;
    logic [30:0]        hlat_reg, hlon_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            logic signed [33:0] cl;
            cl = cx_reg[j][N];
            if (cl > ONE_Q30)
            begin
                cl = ONE_Q30;
            end
            else if (cl < -ONE_Q30)
            begin
                cl = -ONE_Q30;
            end
            cos_c[j] = cf_reg[j][N] ? -cl : cl;
        end
        hv_full[0] = (ONE_Q30 - cos_c[2]) >>> 1;
        hv_full[1] = (ONE_Q30 - cos_c[3]) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        cos1_reg <= cos_c[0][31:0];
        cos2_reg <= cos_c[1][31:0];
        hlat_reg <= hv_full[0][30:0];
        hlon_reg <= hv_full[1][30:0];
    end

    // Product of the latitude cosines
    logic signed [63:0] cc_prod;
    logic signed [31:0] cc_reg;
    logic [30:0]        hlat_c_reg, hlon_c_reg;

    assign cc_prod = cos1_reg * cos2_reg;

    always_ff @(posedge clk)
    begin
        cc_reg     <= 32'(cc_prod >>> 30);
        hlat_c_reg <= hlat_reg;
        hlon_c_reg <= hlon_reg;
    end

    // Haversine sum, clamped to [0, 1]
    logic signed [63:0] t_prod;
    logic signed [33:0] t_term, a_sum;
    logic [30:0]        a_reg;

    assign t_prod = cc_reg * $signed({1'b0, hlon_c_reg});
    assign t_term = 34'(t_prod >>> 30);
    assign a_sum  = t_term + $signed({3'b000, hlat_c_reg});

    always_ff @(posedge clk)
    begin
        if (a_sum[33])
        begin
            a_reg <= '0;
        end
        else if (a_sum > ONE_Q30)
        begin
            a_reg <= 31'(ONE_Q30);
        end
        else
        begin
            a_reg <= a_sum[30:0];
        end
    end

    // Square roots of (1 - a) and a, one root bit per stage
    logic [61:0] sr_rad_reg [2][SQ+1];
    logic [32:0] sr_rem_reg [2][SQ+1];
    logic [30:0] sr_q_reg   [2][SQ+1];
    logic [30:0] a_inv;

    assign a_inv = 31'(ONE_Q30) - a_reg;

    always_ff @(posedge clk)
    begin
        sr_rad_reg[0][0] <= {1'b0, a_inv, 30'd0};
        sr_rad_reg[1][0] <= {1'b0, a_reg, 30'd0};
        sr_rem_reg[0][0] <= '0;
        sr_rem_reg[1][0] <= '0;
        sr_q_reg[0][0]   <= '0;
        sr_q_reg[1][0]   <= '0;
    end

    generate
        for (k = 0; k < 2; k++)
        begin : g_sqrt
            for (i = 0; i < SQ; i++)
            begin : g_st
                logic [34:0] trial_rem;
                logic [34:0] trial_sub;
                assign trial_rem = {sr_rem_reg[k][i], sr_rad_reg[k][i][61:60]};
                assign trial_sub = {2'b00, sr_q_reg[k][i], 2'b01};

                // Bring down two bits, subtract when the trial fits
                always_ff @(posedge clk)
                begin
                    sr_rad_reg[k][i+1] <= {sr_rad_reg[k][i][59:0], 2'b00};
                    if (trial_rem >= trial_sub)
                    begin
                        sr_rem_reg[k][i+1] <= 33'(trial_rem - trial_sub);
                        sr_q_reg[k][i+1]   <= {sr_q_reg[k][i][29:0], 1'b1};
                    end
                    else
                    begin
                        sr_rem_reg[k][i+1] <= trial_rem[32:0];
                        sr_q_reg[k][i+1]   <= {sr_q_reg[k][i][29:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // Vectoring CORDIC for the half central angle
    logic signed [33:0] vx_reg [N];
    logic signed [33:0] vy_reg [N];
    logic signed [33:0] vz_reg [N];

    generate
        for (i = 0; i < N; i++)
        begin : g_vec
            logic signed [33:0] sx, sy, sz, dx, dy, at;
            if (i == 0)
            begin : g_src0
                assign sx = {3'b000, sr_q_reg[0][SQ]};
                assign sy = {3'b000, sr_q_reg[1][SQ]};
                assign sz = '0;
            end
            else
            begin : g_srcn
                assign sx = vx_reg[i-1];
                assign sy = vy_reg[i-1];
                assign sz = vz_reg[i-1];
            end
            assign dx = sy >>> i;
            assign dy = sx >>> i;
            assign at = {2'b00, ATAN_BAM[i]};

            // Drive y toward zero, accumulate the angle
            always_ff @(posedge clk)
            begin
                if (sy > 0)
                begin
                    vx_reg[i] <= sx + dx;
                    vy_reg[i] <= sy - dy;
                    vz_reg[i] <= sz + at;
                end
                else
                begin
                    vx_reg[i] <= sx - dx;
                    vy_reg[i] <= sy + dy;
                    vz_reg[i] <= sz - at;
                end
            end
        end
    endgenerate

    // Clamp the angle and scale by the radius
    logic [30:0] z_clamp;
    logic [55:0] p_reg;
    logic [54:0] hi_reg;
    logic [62:0] lo_reg;

    always_comb
    begin
        if (vz_reg[N-1][33])
        begin
            z_clamp = '0;
        end
        else if (vz_reg[N-1] > ONE_Q30)
        begin
            z_clamp = 31'(ONE_Q30);
        end
        else
        begin
            z_clamp = vz_reg[N-1][30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= radius_reg * z_clamp;
        hi_reg <= p_reg[55:32] * PI_Q29;
        lo_reg <= p_reg[31:0] * PI_Q29;
    end

    // Round half up and saturate
    logic [55:0] dist_sum;
    logic [28:0] dist_round;
    logic [RANGE_W-1:0] range_feet_reg;
    logic               done_reg;

    assign dist_sum   = {1'b0, hi_reg} + {25'd0, lo_reg[62:32]} + (56'd1 << 26);
    assign dist_round = dist_sum[55:27];

    always_ff @(posedge clk)
    begin
        if (dist_round > {2'b00, RANGE_MAX})
        begin
            range_feet_reg <= RANGE_MAX;
        end
        else
        begin
            range_feet_reg <= dist_round[RANGE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[LAT-2];
        end
    end

    assign done       = done_reg;
    assign range_feet = range_feet_reg;

    // Every result traces back to one transfer, and every transfer yields one
    `GCR_ASSERT(a_done_has_src, done |-> $past(start, LAT), "result without transfer")
    `GCR_ASSERT(a_src_gives_done, start |-> ##LAT done, "transfer without result")
    `GCR_ASSERT(a_cfg_write, cfg_valid && cfg_ready |=> radius_reg == $past(cfg_data), "radius write lost")

endmodule

// ----- tb/tb_great_circle_range.sv -----
module tb_great_circle_range;

    import gcr_pkg::*;

    localparam int unsigned STAGES   = CORDIC_STAGES_DEFAULT;
    localparam int unsigned LATENCY  = 2 * STAGES + 39;
    localparam longint      Q30_ONE  = 64'sd1073741824;
    localparam longint      COS_GAIN = 64'sd652032874;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [ANGLE_W-1:0]   lat_this = '0;
    logic signed [ANGLE_W-1:0]   lon_this = '0;
    logic signed [ANGLE_W-1:0]   lat_other = '0;
    logic signed [ANGLE_W-1:0]   lon_other = '0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [RADIUS_W-1:0]         cfg_data = '0;
    logic                        done;
    logic [RANGE_W-1:0]          range_feet;

    logic [RANGE_W-1:0]          range_expect_q [$];
    logic [RADIUS_W-1:0]         radius_shadow = RADIUS_RESET;
    int                          fail_count = 0;

    great_circle_range u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .lat_this   (lat_this),
        .lon_this   (lon_this),
        .lat_other  (lat_other),
        .lon_other  (lon_other),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .range_feet (range_feet)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cosine of a binary angle in Q30: fold to [-90, 90), rotate, clamp
    function automatic longint q30_cosine(logic [31:0] ang);
        logic   flip;
        longint cx;
        longint cy;
        longint cz;
        longint sx;
        longint sy;
        flip = 1'b0;
        cx = COS_GAIN;
        cy = 0;
        if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            ang = ang + 32'h8000_0000;
            flip = 1'b1;
        end
        cz = longint'(signed'(ang));
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cz >= 0)
            begin
                cx = cx - sx;
                cy = cy + sy;
                cz = cz - longint'(ATAN_BAM[i]);
            end
            else
            begin
                cx = cx + sx;
                cy = cy - sy;
                cz = cz + longint'(ATAN_BAM[i]);
            end
        end
        if (cx < -Q30_ONE)
            cx = -Q30_ONE;
        if (cx > Q30_ONE)
            cx = Q30_ONE;
        return flip ? -cx : cx;
    endfunction

    function automatic longint half_versine(logic [31:0] diff);
        return (Q30_ONE - q30_cosine(diff)) >>> 1;
    endfunction

    // Floor square root of a 64-bit value
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Haversine distance in feet for one position pair at the current radius
    function automatic logic [RANGE_W-1:0] predict_range(logic [31:0] la1, logic [31:0] lo1,
                                                        logic [31:0] la2, logic [31:0] lo2,
                                                        logic [RADIUS_W-1:0] radius);
        longint          hlat;
        longint          hlon;
        longint          cc;
        longint          hav;
        longint          vx;
        longint          vy;
        longint          vz;
        longint          sx;
        longint          sy;
        longint unsigned prod;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned dist_round;
        hlat = half_versine(la1 - la2);
        hlon = half_versine(lo1 - lo2);
        cc = (q30_cosine(la1) * q30_cosine(la2)) >>> 30;
        hav = hlat + ((cc * hlon) >>> 30);
        if (hav < 0)
            hav = 0;
        if (hav > Q30_ONE)
            hav = Q30_ONE;
        vx = longint'(floor_sqrt(longint'(Q30_ONE - hav) << 30));
        vy = longint'(floor_sqrt(longint'(hav) << 30));
        vz = 0;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            sx = vy >>> i;
            sy = vx >>> i;
            if (vy > 0)
            begin
                vx = vx + sx;
                vy = vy - sy;
                vz = vz + longint'(ATAN_BAM[i]);
            end
            else
            begin
                vx = vx - sx;
                vy = vy + sy;
                vz = vz - longint'(ATAN_BAM[i]);
            end
        end
        if (vz < 0)
            vz = 0;
        if (vz > Q30_ONE)
            vz = Q30_ONE;
        prod = longint'(radius) * vz;
        hi = (prod >> 32) * longint'(PI_Q29);
        lo = (prod & 64'hFFFF_FFFF) * longint'(PI_Q29);
        dist_round = (hi + (lo >> 32) + (64'd1 << 26)) >> 27;
        if (dist_round > longint'(RANGE_MAX))
            dist_round = longint'(RANGE_MAX);
        return dist_round[RANGE_W-1:0];
    endfunction

    // Check each result against the oldest expected range
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (range_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, range_feet);
                fail_count++;
            end
            else
            begin
                if (range_feet !== range_expect_q[0])
                begin
                    $display("%0t: range_feet mismatch, expected %0d, actual %0d",
                             $time, range_expect_q[0], range_feet);
                    fail_count++;
                end
                void'(range_expect_q.pop_front());
            end
        end
    end

    // Hold start high until the transfer; leave it high for a following pair
    task automatic send_pair(logic [31:0] la1, logic [31:0] lo1,
                             logic [31:0] la2, logic [31:0] lo2);
        start <= 1'b1;
        lat_this <= la1;
        lon_this <= lo1;
        lat_other <= la2;
        lon_other <= lo2;
        do
            @(posedge clk);
        while (busy);
        range_expect_q.push_back(predict_range(la1, lo1, la2, lo2, radius_shadow));
    endtask

    task automatic idle_burst(bit allow);
        if (allow && $urandom_range(3, 0) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every expected range has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (range_expect_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_shadow = value;
    endtask

    function automatic logic [31:0] rand_lat();
        return 32'(longint'($urandom_range(32'h8000_0000, 0)) - Q30_ONE);
    endfunction

    // Mix of far pairs, close pairs, near-antipodal pairs and pole extremes
    task automatic random_pairs(int count, bit allow_idle);
        logic [31:0] la1;
        logic [31:0] lo1;
        logic [31:0] la2;
        logic [31:0] lo2;
        int          kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9, 0);
            la1 = rand_lat();
            lo1 = $urandom();
            la2 = rand_lat();
            lo2 = $urandom();
            if (kind < 3)
            begin
                la2 = 32'(longint'(signed'(la1)) + $signed($urandom_range(2000000, 0)) - 1000000);
                if (signed'(la2) > signed'(32'h4000_0000))
                    la2 = 32'h4000_0000;
                if (signed'(la2) < signed'(32'hC000_0000))
                    la2 = 32'hC000_0000;
                lo2 = lo1 + ($urandom() >> $urandom_range(31, 8));
            end
            else if (kind < 5)
            begin
                la2 = -la1;
                lo2 = lo1 + 32'h8000_0000 + ($urandom() >> $urandom_range(31, 12));
            end
            else if (kind == 5)
            begin
                la1 = $urandom_range(1, 0) ? 32'h4000_0000 : 32'hC000_0000;
            end
            send_pair(la1, lo1, la2, lo2);
            idle_burst(allow_idle);
        end
    endtask

    // Extremes of every field, equal points and antipodes at the current radius
    task automatic test_directed();
        send_pair(32'h0, 32'h0, 32'h0, 32'h0);
        send_pair(32'h4000_0000, 32'h0, 32'hC000_0000, 32'h0);
        send_pair(32'h4000_0000, 32'h8000_0000, 32'h4000_0000, 32'h7FFF_FFFF);
        send_pair(32'hC000_0000, 32'h7FFF_FFFF, 32'hC000_0000, 32'h8000_0000);
        send_pair(32'h0, 32'h0, 32'h0, 32'h8000_0000);
        send_pair(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_pair(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_pair(32'h1234_5678, 32'hDEAD_BEEF, 32'h1234_5678, 32'hDEAD_BEEF);
        send_pair(32'h2000_0000, 32'h4000_0000, 32'hE000_0000, 32'hC000_0000);
        send_pair(32'h4000_0000, 32'h1234_5678, 32'h4000_0000, 32'h9876_5432);
        send_pair(32'hC000_0000, 32'h0, 32'h4000_0000, 32'h8000_0000);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0000_0001);
        send_pair(32'h0000_0001, 32'h0, 32'h0, 32'h0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
        send_pair(32'h3FFF_FFFF, 32'h5555_5555, 32'hC000_0001, 32'hAAAA_AAAA);
        send_pair(32'h0, 32'h4000_0000, 32'h0, 32'hC000_0000);
        send_pair(32'h2AAA_AAAA, 32'h0, 32'hD555_5556, 32'h8000_0000);
        send_pair(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_pair(32'h1000_0000, 32'h0100_0000, 32'h1000_0100, 32'h0100_0100);
        send_pair(32'hF000_0000, 32'h8000_0000, 32'h1000_0000, 32'h0);
    endtask

    task automatic test_default_radius();
        random_pairs(450, 1'b1);
    endtask

    task automatic test_radius_extremes();
        write_radius(25'd1);
        test_directed();
        random_pairs(150, 1'b1);
        write_radius(25'h1FF_FFFF);
        test_directed();
        random_pairs(150, 1'b1);
        write_radius(25'd0);
        random_pairs(30, 1'b1);
    endtask

    task automatic test_random_radius();
        for (int k = 0; k < 4; k++)
        begin
            write_radius(25'($urandom_range(32'h1FF_FFFF, 1)));
            random_pairs(80, 1'b1);
        end
    endtask

    // Back-to-back pairs with no gaps at the default radius
    task automatic test_streaming();
        write_radius(RADIUS_RESET);
        random_pairs(220, 1'b0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_default_radius();
        test_radius_extremes();
        test_random_radius();
        test_streaming();
        start <= 1'b0;
        @(posedge clk);
        while (range_expect_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (fail_count == 0)
            $display("great_circle_range test passed");
        else
            $display("great_circle_range test failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("great_circle_range test failed");
        $finish;
    end

endmodule

// ----- great_circle_range.f -----
+incdir+rtl
rtl/gcr_pkg.sv
rtl/great_circle_range.sv
tb/tb_great_circle_range.sv
